[sv/coe_pkg.sv]
// Shared types, constants and codes of the clock offset estimator.
`default_nettype none

package coe_pkg;

    // Sample ring geometry.
    localparam int SAMPLE_SLOTS = 8;
    localparam int SLOT_W = $clog2(SAMPLE_SLOTS);
    localparam int COUNT_W = $clog2(SAMPLE_SLOTS + 1);

    // Field widths.
    localparam int TIME_W = 64;
    localparam int CFG_W = 40;
    localparam int SMALL_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int SAMPLE_W = 2 * TIME_W;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic signed [TIME_W-1:0] stime_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Command codes of an input beat.
    typedef enum logic [1:0] {
        CMD_PROBE   = 2'd0,
        CMD_REPLY   = 2'd1,
        CMD_CONVERT = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEADY_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_SAMPLES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN_SAMPLES = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_REPLY_TIMEOUT    = 40'd10000000000;
    localparam logic [CFG_W-1:0] RST_STARTUP_INTERVAL = 40'd1000000000;
    localparam logic [CFG_W-1:0] RST_STEADY_INTERVAL  = 40'd30000000000;
    localparam logic [SMALL_W-1:0] RST_STARTUP_SAMPLES  = 7'd4;
    localparam logic [SMALL_W-1:0] RST_SYNC_MIN_SAMPLES = 7'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PROBE,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Start request from the controller to the minimum scanner.
    typedef struct packed {
        logic   start;
        count_t count;
    } scan_req_t;

    // Status and running minimum from the scanner.
    typedef struct packed {
        logic   done;
        time_t  best_rtt;
        stime_t best_offset;
    } scan_status_t;

endpackage

`default_nettype wire

[sv/coe_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module coe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read; a read at the same edge as a write to that entry returns the old
    // data, and a read in the cycle after the write sees the new data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/coe_sample_calc.sv]
// Round trip and midpoint offset of one four-timestamp reply; differences registered, final step combinational.
`default_nettype none

module coe_sample_calc (
    input  wire logic            clk,
    input  wire logic            load,
    input  wire coe_pkg::time_t  cs,
    input  wire coe_pkg::time_t  br,
    input  wire coe_pkg::time_t  bs,
    input  wire coe_pkg::time_t  cr,
    output coe_pkg::time_t       rtt,
    output coe_pkg::stime_t      offset
);

    coe_pkg::time_t  el_reg;
    coe_pkg::time_t  bel_reg;
    coe_pkg::stime_t d_rx_reg;
    coe_pkg::stime_t d_tx_reg;
    logic [coe_pkg::TIME_W:0] rtt_diff;

    // Signed difference of two unsigned times, clamped to the signed range.
    function automatic coe_pkg::stime_t sat_diff(input coe_pkg::time_t a,
                                                 input coe_pkg::time_t b);
        logic [coe_pkg::TIME_W:0] d;
        coe_pkg::stime_t res;
        d = {1'b0, a} - {1'b0, b};
        if (d[coe_pkg::TIME_W] == d[coe_pkg::TIME_W-1])
        begin
            res = d[coe_pkg::TIME_W-1:0];
        end
        else if (!d[coe_pkg::TIME_W])
        begin
            res = {1'b0, {(coe_pkg::TIME_W-1){1'b1}}};
        end
        else
        begin
            res = {1'b1, {(coe_pkg::TIME_W-1){1'b0}}};
        end
        return res;
    endfunction

    // Average: each half truncated toward zero, plus half the sum of the remainders.
    function automatic coe_pkg::stime_t trunc_avg(input coe_pkg::stime_t a,
                                                  input coe_pkg::stime_t b);
        logic signed [coe_pkg::TIME_W:0] ha;
        logic signed [coe_pkg::TIME_W:0] hb;
        logic signed [coe_pkg::TIME_W:0] corr;
        logic signed [coe_pkg::TIME_W:0] sum;
        ha = ($signed({a[coe_pkg::TIME_W-1], a})
              + $signed({{coe_pkg::TIME_W{1'b0}}, a[coe_pkg::TIME_W-1] & a[0]})) >>> 1;
        hb = ($signed({b[coe_pkg::TIME_W-1], b})
              + $signed({{coe_pkg::TIME_W{1'b0}}, b[coe_pkg::TIME_W-1] & b[0]})) >>> 1;
        if (a[0] && b[0] && (a[coe_pkg::TIME_W-1] == b[coe_pkg::TIME_W-1]))
        begin
            corr = a[coe_pkg::TIME_W-1] ? '1 : (coe_pkg::TIME_W+1)'(1);
        end
        else
        begin
            corr = '0;
        end
        sum = ha + hb + corr;
        return sum[coe_pkg::TIME_W-1:0];
    endfunction

    // First stage: elapsed times and the two saturated one-way differences.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            el_reg   <= cr - cs;
            bel_reg  <= bs - br;
            d_rx_reg <= sat_diff(br, cs);
            d_tx_reg <= sat_diff(bs, cr);
        end
    end

    // Second stage: round trip floored at zero, and the midpoint offset.
    assign rtt_diff = {1'b0, el_reg} - {1'b0, bel_reg};
    assign rtt      = rtt_diff[coe_pkg::TIME_W] ? '0 : rtt_diff[coe_pkg::TIME_W-1:0];
    assign offset   = trunc_avg(d_rx_reg, d_tx_reg);

endmodule

`default_nettype wire

[sv/coe_min_scan.sv]
// Walks the stored samples through the RAM read port and keeps the lowest round trip.
`default_nettype none

module coe_min_scan (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire coe_pkg::scan_req_t          req,
    output coe_pkg::slot_t                   raddr,
    input  wire logic [coe_pkg::SAMPLE_W-1:0] rdata,
    output coe_pkg::scan_status_t            status
);

    logic            busy_reg;
    logic            pend_reg;
    logic            first_reg;
    coe_pkg::count_t issue_reg;
    coe_pkg::count_t count_reg;
    coe_pkg::time_t  best_rtt_reg;
    coe_pkg::stime_t best_off_reg;
    logic            issuing;
    logic            done;
    coe_pkg::time_t  rd_rtt;
    coe_pkg::stime_t rd_off;

    // Read address and completion; data arrives in the cycle after each address.
    assign issuing = busy_reg && (issue_reg < count_reg);
    assign done    = busy_reg && (issue_reg == count_reg) && !pend_reg;
    assign raddr   = issue_reg[coe_pkg::SLOT_W-1:0];
    assign rd_rtt  = rdata[coe_pkg::SAMPLE_W-1:coe_pkg::TIME_W];
    assign rd_off  = rdata[coe_pkg::TIME_W-1:0];

    // Scan sequencer and running minimum; strict compare keeps the lowest slot on ties.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            first_reg    <= 1'b0;
            issue_reg    <= '0;
            count_reg    <= '0;
            best_rtt_reg <= '0;
            best_off_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            pend_reg  <= 1'b0;
            first_reg <= 1'b1;
            issue_reg <= '0;
            count_reg <= req.count;
        end
        else if (busy_reg)
        begin
            pend_reg <= issuing;
            if (issuing)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (pend_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg || (rd_rtt < best_rtt_reg))
                begin
                    best_rtt_reg <= rd_rtt;
                    best_off_reg <= rd_off;
                end
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign status.done        = done;
    assign status.best_rtt    = best_rtt_reg;
    assign status.best_offset = best_off_reg;

endmodule

`default_nettype wire

[sv/clock_offset_estimator.sv]
// Top level of the four-timestamp clock offset estimator.
`default_nettype none

// Clock offset estimator. Each input beat is one command: a probe tick decides
// whether a sync request goes out now, a reply with four timestamps adds a
// sample to a ring of SAMPLE_SLOTS entries held in one RAM, and a convert maps
// server time to client time through the offset of the lowest-round-trip
// sample. Every input beat gives exactly one result beat. Items are handled
// one at a time: a probe passes through the execute, probe and done states,
// a convert or a rejected reply through execute and done, and an accepted
// reply through execute, write, scan and done, where the scan walks the N
// stored samples (at most SAMPLE_SLOTS) and reads one sample per cycle through
// the single RAM read port. A finished result waits in the output register
// while the next beat is accepted. The sample RAM needs no clearing after
// reset: only slots already written are searched.
module clock_offset_estimator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port
    input  wire logic                              cfg_write,
    input  wire logic [coe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [coe_pkg::CFG_W-1:0]         cfg_wdata,
    // Input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        cmd,
    input  wire coe_pkg::time_t                    now_time,
    input  wire coe_pkg::time_t                    client_send_time,
    input  wire coe_pkg::time_t                    backend_receive_time,
    input  wire coe_pkg::time_t                    backend_send_time,
    input  wire coe_pkg::time_t                    client_receive_time,
    input  wire coe_pkg::time_t                    server_time,
    // Output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   ok,
    output coe_pkg::time_t                         probe_time,
    output coe_pkg::time_t                         client_time,
    output coe_pkg::time_t                         best_round_trip,
    output coe_pkg::stime_t                        clock_offset,
    output logic                                   synced
);

    // Configuration registers.
    logic [coe_pkg::CFG_W-1:0]   reply_timeout_reg;
    logic [coe_pkg::CFG_W-1:0]   startup_interval_reg;
    logic [coe_pkg::CFG_W-1:0]   steady_interval_reg;
    logic [coe_pkg::SMALL_W-1:0] startup_samples_reg;
    logic [coe_pkg::SMALL_W-1:0] sync_min_samples_reg;

    // Controller state.
    coe_pkg::state_t state_reg;
    coe_pkg::state_t state_next;

    // Captured input beat.
    coe_pkg::cmd_t   cmd_reg;
    coe_pkg::time_t  now_reg;
    coe_pkg::time_t  cs_reg;
    coe_pkg::time_t  br_reg;
    coe_pkg::time_t  bs_reg;
    coe_pkg::time_t  cr_reg;
    coe_pkg::time_t  st_reg;

    // Estimator state held in flops.
    logic            awaiting_reg;
    coe_pkg::time_t  pending_send_reg;
    coe_pkg::time_t  last_probe_reg;
    coe_pkg::count_t stored_count_reg;
    coe_pkg::slot_t  write_slot_reg;
    logic            sync_reg;

    // Probe differences computed in the execute cycle.
    logic [coe_pkg::TIME_W:0]  pend_diff_reg;
    logic [coe_pkg::TIME_W:0]  last_diff_reg;
    logic [coe_pkg::CFG_W-1:0] interval_reg;

    // Result held until the output register is free.
    logic            res_ok_reg;
    coe_pkg::time_t  res_probe_reg;
    coe_pkg::time_t  res_client_reg;

    // Output register.
    logic            out_valid_reg;
    logic            ok_reg;
    coe_pkg::time_t  probe_time_reg;
    coe_pkg::time_t  client_time_reg;
    coe_pkg::time_t  best_rtt_reg;
    coe_pkg::stime_t clock_offset_reg;
    logic            synced_reg;

    // Control strobes.
    logic in_take;
    logic exec_probe;
    logic exec_sample;
    logic exec_finish;
    logic probe_commit;
    logic sample_write;
    logic scan_finish;
    logic out_load;

    logic            reply_ok;
    logic            refuse_await;
    logic            refuse_space;
    logic            proceed;
    logic [coe_pkg::TIME_W+1:0] conv_diff;
    coe_pkg::time_t  conv_time;
    coe_pkg::count_t count_inc;

    coe_pkg::time_t  sample_rtt;
    coe_pkg::stime_t sample_off;
    coe_pkg::scan_req_t    scan_req;
    coe_pkg::scan_status_t scan_status;
    coe_pkg::slot_t        ram_raddr;
    logic [coe_pkg::SAMPLE_W-1:0] ram_rdata;

    // Reply acceptance check on the captured beat.
    assign reply_ok = awaiting_reg && (cs_reg == pending_send_reg)
                      && (cr_reg >= cs_reg) && (bs_reg >= br_reg);

    // Probe decision from the registered differences.
    assign refuse_await = awaiting_reg && !pend_diff_reg[coe_pkg::TIME_W]
        && (pend_diff_reg[coe_pkg::TIME_W-1:0]
            <= coe_pkg::TIME_W'(reply_timeout_reg));
    assign refuse_space = (last_probe_reg != '0) && !last_diff_reg[coe_pkg::TIME_W]
        && (last_diff_reg[coe_pkg::TIME_W-1:0] < coe_pkg::TIME_W'(interval_reg));
    assign proceed = !refuse_await && !refuse_space;

    // Server to client time: server_time minus offset, clamped to the unsigned range.
    assign conv_diff = {2'b00, st_reg}
        - {{2{scan_status.best_offset[coe_pkg::TIME_W-1]}}, scan_status.best_offset};
    always_comb
    begin
        if (conv_diff[coe_pkg::TIME_W+1])
        begin
            conv_time = '0;
        end
        else if (conv_diff[coe_pkg::TIME_W])
        begin
            conv_time = '1;
        end
        else
        begin
            conv_time = conv_diff[coe_pkg::TIME_W-1:0];
        end
    end

    assign count_inc = (stored_count_reg == coe_pkg::COUNT_W'(coe_pkg::SAMPLE_SLOTS))
                       ? stored_count_reg : stored_count_reg + 1'b1;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            coe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = coe_pkg::ST_EXEC;
                end
            end
            coe_pkg::ST_EXEC:
            begin
                if (cmd_reg == coe_pkg::CMD_PROBE)
                begin
                    state_next = coe_pkg::ST_PROBE;
                end
                else if ((cmd_reg == coe_pkg::CMD_REPLY) && reply_ok)
                begin
                    state_next = coe_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = coe_pkg::ST_DONE;
                end
            end
            coe_pkg::ST_PROBE:
            begin
                state_next = coe_pkg::ST_DONE;
            end
            coe_pkg::ST_WRITE:
            begin
                state_next = coe_pkg::ST_SCAN;
            end
            coe_pkg::ST_SCAN:
            begin
                if (scan_status.done)
                begin
                    state_next = coe_pkg::ST_DONE;
                end
            end
            coe_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = coe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = coe_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and strobe logic of the controller.
    always_comb
    begin
        in_ready     = 1'b0;
        in_take      = 1'b0;
        exec_probe   = 1'b0;
        exec_sample  = 1'b0;
        exec_finish  = 1'b0;
        probe_commit = 1'b0;
        sample_write = 1'b0;
        scan_finish  = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            coe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                in_take  = in_valid;
            end
            coe_pkg::ST_EXEC:
            begin
                if (cmd_reg == coe_pkg::CMD_PROBE)
                begin
                    exec_probe = 1'b1;
                end
                else if ((cmd_reg == coe_pkg::CMD_REPLY) && reply_ok)
                begin
                    exec_sample = 1'b1;
                end
                else
                begin
                    exec_finish = 1'b1;
                end
            end
            coe_pkg::ST_PROBE:
            begin
                probe_commit = 1'b1;
            end
            coe_pkg::ST_WRITE:
            begin
                sample_write = 1'b1;
            end
            coe_pkg::ST_SCAN:
            begin
                scan_finish = scan_status.done;
            end
            coe_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Controller state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= coe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers; writes are masked to each register's width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_timeout_reg    <= coe_pkg::RST_REPLY_TIMEOUT;
            startup_interval_reg <= coe_pkg::RST_STARTUP_INTERVAL;
            steady_interval_reg  <= coe_pkg::RST_STEADY_INTERVAL;
            startup_samples_reg  <= coe_pkg::RST_STARTUP_SAMPLES;
            sync_min_samples_reg <= coe_pkg::RST_SYNC_MIN_SAMPLES;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                coe_pkg::CFG_REPLY_TIMEOUT:    reply_timeout_reg    <= cfg_wdata;
                coe_pkg::CFG_STARTUP_INTERVAL: startup_interval_reg <= cfg_wdata;
                coe_pkg::CFG_STEADY_INTERVAL:  steady_interval_reg  <= cfg_wdata;
                coe_pkg::CFG_STARTUP_SAMPLES:
                    startup_samples_reg <= cfg_wdata[coe_pkg::SMALL_W-1:0];
                coe_pkg::CFG_SYNC_MIN_SAMPLES:
                    sync_min_samples_reg <= cfg_wdata[coe_pkg::SMALL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input capture and probe differences.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg <= coe_pkg::cmd_t'(cmd);
            now_reg <= now_time;
            cs_reg  <= client_send_time;
            br_reg  <= backend_receive_time;
            bs_reg  <= backend_send_time;
            cr_reg  <= client_receive_time;
            st_reg  <= server_time;
        end
        if (exec_probe)
        begin
            pend_diff_reg <= {1'b0, now_reg} - {1'b0, pending_send_reg};
            last_diff_reg <= {1'b0, now_reg} - {1'b0, last_probe_reg};
            interval_reg  <= (coe_pkg::SMALL_W'(stored_count_reg) < startup_samples_reg)
                             ? startup_interval_reg : steady_interval_reg;
        end
    end

    // Estimator state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg     <= 1'b0;
            pending_send_reg <= '0;
            last_probe_reg   <= '0;
            stored_count_reg <= '0;
            write_slot_reg   <= '0;
            sync_reg         <= 1'b0;
        end
        else
        begin
            if (probe_commit)
            begin
                if (proceed)
                begin
                    awaiting_reg     <= 1'b1;
                    pending_send_reg <= now_reg;
                    last_probe_reg   <= now_reg;
                end
                else if (!refuse_await)
                begin
                    awaiting_reg <= 1'b0;
                end
            end
            if (sample_write)
            begin
                awaiting_reg     <= 1'b0;
                stored_count_reg <= count_inc;
                write_slot_reg   <= (write_slot_reg
                                     == coe_pkg::SLOT_W'(coe_pkg::SAMPLE_SLOTS - 1))
                                    ? '0 : write_slot_reg + 1'b1;
            end
            if (scan_finish)
            begin
                sync_reg <= coe_pkg::SMALL_W'(stored_count_reg) >= sync_min_samples_reg;
            end
        end
    end

    // Result fields of the current item.
    always_ff @(posedge clk)
    begin
        if (exec_finish)
        begin
            res_ok_reg     <= (cmd_reg == coe_pkg::CMD_CONVERT) && sync_reg;
            res_probe_reg  <= '0;
            res_client_reg <= ((cmd_reg == coe_pkg::CMD_CONVERT) && sync_reg)
                              ? conv_time : '0;
        end
        if (probe_commit)
        begin
            res_ok_reg     <= proceed;
            res_probe_reg  <= proceed ? now_reg : '0;
            res_client_reg <= '0;
        end
        if (sample_write)
        begin
            res_ok_reg     <= 1'b1;
            res_probe_reg  <= '0;
            res_client_reg <= '0;
        end
    end

    // Output register: valid bit is control, fields are payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ok_reg           <= res_ok_reg;
            probe_time_reg   <= res_probe_reg;
            client_time_reg  <= res_client_reg;
            best_rtt_reg     <= scan_status.best_rtt;
            clock_offset_reg <= scan_status.best_offset;
            synced_reg       <= sync_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = ok_reg;
    assign probe_time      = probe_time_reg;
    assign client_time     = client_time_reg;
    assign best_round_trip = best_rtt_reg;
    assign clock_offset    = clock_offset_reg;
    assign synced          = synced_reg;

    // Sample computation for an accepted reply.
    coe_sample_calc u_sample_calc (
        .clk    (clk),
        .load   (exec_sample),
        .cs     (cs_reg),
        .br     (br_reg),
        .bs     (bs_reg),
        .cr     (cr_reg),
        .rtt    (sample_rtt),
        .offset (sample_off)
    );

    // Sample ring: round trip in the upper half, offset in the lower half.
    // The scan starts the cycle after the write, so the read sees the new entry.
    coe_ram #(
        .WIDTH (coe_pkg::SAMPLE_W),
        .DEPTH (coe_pkg::SAMPLE_SLOTS)
    ) u_sample_ram (
        .clk   (clk),
        .we    (sample_write),
        .waddr (write_slot_reg),
        .wdata ({sample_rtt, sample_off}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_req.start = sample_write;
    assign scan_req.count = count_inc;

    // Minimum round trip search over the stored slots.
    coe_min_scan u_min_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (scan_req),
        .raddr  (ram_raddr),
        .rdata  (ram_rdata),
        .status (scan_status)
    );

endmodule

`default_nettype wire

[sv/coe_checker.sv]
// Port-level checks of the clock offset estimator and their binding.
`default_nettype none

module coe_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire logic           ok,
    input wire coe_pkg::time_t probe_time,
    input wire coe_pkg::time_t client_time,
    input wire coe_pkg::time_t best_round_trip,
    input wire logic           synced
);

    // A stalled result beat keeps its round trip field.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(best_round_trip))
    else $error("stalled result beat changed");

    // Items are handled one at a time: no beat is taken right after an accepted one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

    // A nonzero converted time only comes from a valid conversion while synced.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (client_time != '0) |-> ok && synced)
    else $error("converted time without a valid conversion");

    // A nonzero probe time marks an issued probe and never a conversion.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (probe_time != '0) |-> ok && (client_time == '0))
    else $error("probe time on a result that is not an issued probe");

endmodule

bind clock_offset_estimator coe_checker u_coe_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .ok              (ok),
    .probe_time      (probe_time),
    .client_time     (client_time),
    .best_round_trip (best_round_trip),
    .synced          (synced)
);

`default_nettype wire

[verif/coe_checker.sv]
// Scoreboard of the clock offset estimator: predicts each result beat and compares it.
module coe_scoreboard (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [coe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [coe_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [1:0]                    cmd,
    input  wire coe_pkg::time_t                now_time,
    input  wire coe_pkg::time_t                client_send_time,
    input  wire coe_pkg::time_t                backend_receive_time,
    input  wire coe_pkg::time_t                backend_send_time,
    input  wire coe_pkg::time_t                client_receive_time,
    input  wire coe_pkg::time_t                server_time,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic                          ok,
    input  wire coe_pkg::time_t                probe_time,
    input  wire coe_pkg::time_t                client_time,
    input  wire coe_pkg::time_t                best_round_trip,
    input  wire coe_pkg::stime_t               clock_offset,
    input  wire logic                          synced,
    output int                                 fail_count,
    output int                                 owed_count
);

    typedef coe_pkg::time_t time_t;

    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = -S64_MAX - 1;
    localparam time_t U64_MAX = '1;
    localparam int MAX_REPORTS = 10;

    // One predicted result beat.
    typedef struct packed {
        logic           granted;
        time_t          probe;
        time_t          conv;
        time_t          rtt;
        coe_pkg::stime_t ofs;
        logic           locked;
    } estimate_t;

    // Copy of the configuration registers.
    time_t to_ns;
    time_t start_gap_ns;
    time_t steady_gap_ns;
    int    start_cnt;
    int    lock_cnt;

    // Copy of the estimator state.
    logic   probe_out;
    time_t  out_stamp;
    time_t  prev_probe;
    int     n_samples;
    int     next_slot;
    time_t  ring_rtt [coe_pkg::SAMPLE_SLOTS];
    longint ring_ofs [coe_pkg::SAMPLE_SLOTS];
    time_t  sel_rtt;
    longint sel_ofs;
    logic   in_sync;

    estimate_t owed [$];
    int fails = 0;

    // Signed difference a - b, pinned to the 64-bit signed range.
    function automatic longint sat_sub(time_t a, time_t b);
        time_t mag;
        if (a >= b)
        begin
            mag = a - b;
            return (mag > time_t'(S64_MAX)) ? S64_MAX : longint'(mag);
        end
        mag = b - a;
        return (mag > time_t'(S64_MAX)) ? S64_MIN : -longint'(mag);
    endfunction

    // Midpoint of two offsets, each half truncated toward zero.
    function automatic longint mid_offset(longint a, longint b);
        return a / 2 + b / 2 + (a % 2 + b % 2) / 2;
    endfunction

    // Probe tick: a pending request blocks until its timeout, then spacing applies.
    function automatic logic try_probe(time_t now);
        time_t gap;
        if (probe_out)
        begin
            if (now >= out_stamp && now - out_stamp <= to_ns)
                return 1'b0;
            probe_out = 1'b0;
        end
        gap = (n_samples < start_cnt) ? start_gap_ns : steady_gap_ns;
        if (prev_probe != 0 && now >= prev_probe && now - prev_probe < gap)
            return 1'b0;
        prev_probe = now;
        out_stamp = now;
        probe_out = 1'b1;
        return 1'b1;
    endfunction

    // Reply: store the sample and pick the lowest round trip, lowest slot on ties.
    function automatic logic try_reply(time_t cs, time_t br, time_t bs, time_t cr);
        time_t c_el;
        time_t s_el;
        int slot;
        int pick;
        int idx;
        if (!probe_out || cs != out_stamp || cr < cs || bs < br)
            return 1'b0;
        probe_out = 1'b0;
        c_el = cr - cs;
        s_el = bs - br;
        slot = next_slot;
        ring_rtt[slot] = (c_el >= s_el) ? c_el - s_el : '0;
        ring_ofs[slot] = mid_offset(sat_sub(br, cs), sat_sub(bs, cr));
        if (n_samples < coe_pkg::SAMPLE_SLOTS)
            n_samples++;
        next_slot = (slot + 1) % coe_pkg::SAMPLE_SLOTS;
        pick = 0;
        for (idx = 1; idx < n_samples; idx++)
            if (ring_rtt[idx] < ring_rtt[pick])
                pick = idx;
        sel_rtt = ring_rtt[pick];
        sel_ofs = ring_ofs[pick];
        in_sync = n_samples >= lock_cnt;
        return 1'b1;
    endfunction

    // Advance the prediction by one command beat and return its result.
    function automatic estimate_t estimate_step(logic [1:0] op, time_t now, time_t cs,
                                                time_t br, time_t bs, time_t cr, time_t st);
        estimate_t r;
        time_t mag;
        r = '0;
        case (op)
            coe_pkg::CMD_PROBE:
            begin
                r.granted = try_probe(now);
                if (r.granted)
                    r.probe = now;
            end
            coe_pkg::CMD_REPLY:
            begin
                r.granted = try_reply(cs, br, bs, cr);
            end
            coe_pkg::CMD_CONVERT:
            begin
                if (in_sync)
                begin
                    r.granted = 1'b1;
                    if (sel_ofs >= 0)
                    begin
                        mag = time_t'(sel_ofs);
                        r.conv = (st >= mag) ? st - mag : '0;
                    end
                    else
                    begin
                        mag = time_t'(0) - time_t'(sel_ofs);
                        r.conv = (U64_MAX - st < mag) ? U64_MAX : st + mag;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.rtt = sel_rtt;
        r.ofs = sel_ofs;
        r.locked = in_sync;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        estimate_t got;
        estimate_t want;
        if (!rst_n)
        begin
            to_ns = time_t'(coe_pkg::RST_REPLY_TIMEOUT);
            start_gap_ns = time_t'(coe_pkg::RST_STARTUP_INTERVAL);
            steady_gap_ns = time_t'(coe_pkg::RST_STEADY_INTERVAL);
            start_cnt = int'(coe_pkg::RST_STARTUP_SAMPLES);
            lock_cnt = int'(coe_pkg::RST_SYNC_MIN_SAMPLES);
            probe_out = 1'b0;
            out_stamp = '0;
            prev_probe = '0;
            n_samples = 0;
            next_slot = 0;
            foreach (ring_rtt[i])
            begin
                ring_rtt[i] = '0;
                ring_ofs[i] = 0;
            end
            sel_rtt = '0;
            sel_ofs = 0;
            in_sync = 1'b0;
            owed.delete();
        end
        else
        begin
            // Register writes update the predictor's copy; unused indexes do nothing.
            if (cfg_write)
            begin
                case (cfg_index)
                    coe_pkg::CFG_REPLY_TIMEOUT:    to_ns = time_t'(cfg_wdata);
                    coe_pkg::CFG_STARTUP_INTERVAL: start_gap_ns = time_t'(cfg_wdata);
                    coe_pkg::CFG_STEADY_INTERVAL:  steady_gap_ns = time_t'(cfg_wdata);
                    coe_pkg::CFG_STARTUP_SAMPLES:
                        start_cnt = int'(cfg_wdata[coe_pkg::SMALL_W-1:0]);
                    coe_pkg::CFG_SYNC_MIN_SAMPLES:
                        lock_cnt = int'(cfg_wdata[coe_pkg::SMALL_W-1:0]);
                    default:
                    begin
                    end
                endcase
            end

            // Every accepted command beat owes one result beat.
            if (in_valid && in_ready)
                owed.push_back(estimate_step(cmd, now_time, client_send_time,
                                             backend_receive_time, backend_send_time,
                                             client_receive_time, server_time));

            // Each result beat settles the oldest owed estimate.
            if (out_valid && out_ready)
            begin
                got = '{ok, probe_time, client_time, best_round_trip, clock_offset, synced};
                if (owed.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: result beat with nothing owed: ok=%0b", $time, ok);
                end
                else
                begin
                    want = owed.pop_front();
                    if (got.granted !== want.granted || got.probe !== want.probe ||
                        got.conv !== want.conv || got.rtt !== want.rtt ||
                        got.ofs !== want.ofs || got.locked !== want.locked)
                    begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%0t: mismatch exp ok=%0b probe=%0h ctime=%0h",
                                     $time, want.granted, want.probe, want.conv,
                                     " rtt=%0h ofs=%0d synced=%0b", want.rtt,
                                     want.ofs, want.locked,
                                     " / got ok=%0b probe=%0h ctime=%0h", got.granted,
                                     got.probe, got.conv,
                                     " rtt=%0h ofs=%0d synced=%0b", got.rtt,
                                     got.ofs, got.locked);
                    end
                end
            end
        end
        fail_count <= fails;
        owed_count <= owed.size();
    end

endmodule

[verif/clock_offset_estimator_tb.sv]
// Testbench top of the clock offset estimator: stimulus, flow control and verdict.
module clock_offset_estimator_tb;

    typedef coe_pkg::time_t  time_t;
    typedef coe_pkg::stime_t stime_t;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_BEATS = 320;
    localparam logic [coe_pkg::CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;
    localparam logic [coe_pkg::CFG_W-1:0] CFG_MAX = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_write = 1'b0;
    logic [coe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [coe_pkg::CFG_W-1:0]     cfg_wdata = '0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] cmd = coe_pkg::CMD_PROBE;
    time_t      now_time = '0;
    time_t      client_send_time = '0;
    time_t      backend_receive_time = '0;
    time_t      backend_send_time = '0;
    time_t      client_receive_time = '0;
    time_t      server_time = '0;

    logic   out_valid;
    logic   out_ready = 1'b0;
    logic   ok;
    time_t  probe_time;
    time_t  client_time;
    time_t  best_round_trip;
    stime_t clock_offset;
    logic   synced;

    int fail_count;
    int owed_count;

    // Stimulus bookkeeping: client clock, register mirror and flow control.
    time_t wall = '0;
    time_t cur_timeout = time_t'(coe_pkg::RST_REPLY_TIMEOUT);
    time_t cur_start = time_t'(coe_pkg::RST_STARTUP_INTERVAL);
    time_t cur_steady = time_t'(coe_pkg::RST_STEADY_INTERVAL);
    int    beats_sent = 0;
    int    stall_cycles = 0;
    logic  steady_flow = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    clock_offset_estimator dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .cmd                  (cmd),
        .now_time             (now_time),
        .client_send_time     (client_send_time),
        .backend_receive_time (backend_receive_time),
        .backend_send_time    (backend_send_time),
        .client_receive_time  (client_receive_time),
        .server_time          (server_time),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .ok                   (ok),
        .probe_time           (probe_time),
        .client_time          (client_time),
        .best_round_trip      (best_round_trip),
        .clock_offset         (clock_offset),
        .synced               (synced)
    );

    coe_scoreboard watcher (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .cmd                  (cmd),
        .now_time             (now_time),
        .client_send_time     (client_send_time),
        .backend_receive_time (backend_receive_time),
        .backend_send_time    (backend_send_time),
        .client_receive_time  (client_receive_time),
        .server_time          (server_time),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .ok                   (ok),
        .probe_time           (probe_time),
        .client_time          (client_time),
        .best_round_trip      (best_round_trip),
        .clock_offset         (clock_offset),
        .synced               (synced),
        .fail_count           (fail_count),
        .owed_count           (owed_count)
    );

    // The result side stalls at random except during the steady stretch.
    always @(posedge clk)
    begin
        out_ready <= steady_flow || ($urandom_range(99, 0) >= 32);
    end

    // Watchdog: too many cycles without any beat ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("clock_offset_estimator_tb NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic time_t rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one command beat after an optional random gap, then wait for acceptance.
    task automatic send_beat(input coe_pkg::cmd_t op, input time_t now, input time_t cs,
                             input time_t br, input time_t bs, input time_t cr,
                             input time_t st);
        while (!steady_flow && $urandom_range(99, 0) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        now_time <= now;
        client_send_time <= cs;
        backend_receive_time <= br;
        backend_send_time <= bs;
        client_receive_time <= cr;
        server_time <= st;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op != coe_pkg::CMD_NONE)
            beats_sent++;
    endtask

    // Unused fields of each command carry random bits.
    task automatic probe_at(input time_t now);
        send_beat(coe_pkg::CMD_PROBE, now, rand64(), rand64(), rand64(), rand64(),
                  rand64());
    endtask

    task automatic send_reply(input time_t cs, input time_t br, input time_t bs,
                              input time_t cr);
        send_beat(coe_pkg::CMD_REPLY, rand64(), cs, br, bs, cr, rand64());
    endtask

    task automatic convert_at(input time_t st);
        send_beat(coe_pkg::CMD_CONVERT, rand64(), rand64(), rand64(), rand64(), rand64(),
                  st);
    endtask

    // Stop sending and wait until every owed result has arrived, then settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_count != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write every register once, plus an unused index that must be ignored.
    task automatic apply_config(input time_t t_out, input time_t t_start,
                                input time_t t_steady, input int n_start, input int n_sync);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= coe_pkg::CFG_REPLY_TIMEOUT;
        cfg_wdata <= t_out[coe_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= coe_pkg::CFG_STARTUP_INTERVAL;
        cfg_wdata <= t_start[coe_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= coe_pkg::CFG_STEADY_INTERVAL;
        cfg_wdata <= t_steady[coe_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= coe_pkg::CFG_STARTUP_SAMPLES;
        cfg_wdata <= coe_pkg::CFG_W'(n_start);
        @(posedge clk);
        cfg_index <= coe_pkg::CFG_SYNC_MIN_SAMPLES;
        cfg_wdata <= coe_pkg::CFG_W'(n_sync);
        @(posedge clk);
        cfg_index <= CFG_SPARE_INDEX;
        cfg_wdata <= coe_pkg::CFG_W'(rand64());
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_timeout = time_t'(t_out[coe_pkg::CFG_W-1:0]);
        cur_start = time_t'(t_start[coe_pkg::CFG_W-1:0]);
        cur_steady = time_t'(t_steady[coe_pkg::CFG_W-1:0]);
    endtask

    // Clock advance before a probe: mostly past every limit, sometimes right at one.
    function automatic time_t pick_gap();
        time_t wide;
        wide = cur_timeout;
        if (cur_start > wide)
            wide = cur_start;
        if (cur_steady > wide)
            wide = cur_steady;
        wide = wide + 1;
        case ($urandom_range(9, 0))
            0: return time_t'($urandom_range(3, 0));
            1: return rand64() % wide;
            2:
            begin
                case ($urandom_range(5, 0))
                    0: return cur_start;
                    1: return cur_start - 1;
                    2: return cur_steady;
                    3: return cur_steady - 1;
                    4: return cur_timeout;
                    default: return cur_timeout + 1;
                endcase
            end
            default: return wide + time_t'($urandom_range(1 << 16, 0));
        endcase
    endfunction

    function automatic time_t pick_server_time();
        case ($urandom_range(3, 0))
            0: return '0;
            1: return '1;
            2: return rand64();
            default: return wall + time_t'($urandom_range(1 << 20, 0));
        endcase
    endfunction

    // Mostly well-formed probe and reply exchanges, the rest noise and broken replies.
    task automatic run_random(input int beats);
        int goal;
        logic [31:0] w;
        time_t fwd;
        time_t back;
        time_t proc;
        time_t shift;
        time_t br;
        time_t bs;
        time_t cr;
        goal = beats_sent + beats;
        wall = rand64() >> 2;
        while (beats_sent < goal)
        begin
            if ($urandom_range(99, 0) < 72)
            begin
                wall = wall + pick_gap();
                probe_at(wall);
                if ($urandom_range(4, 0) == 0)
                    convert_at(pick_server_time());
                if ($urandom_range(9, 0) != 0)
                begin
                    fwd = time_t'($urandom_range(100000, 0));
                    back = time_t'($urandom_range(100000, 0));
                    proc = time_t'($urandom_range(50000, 0));
                    // Equal round trips exercise the lowest-slot tie rule.
                    if ($urandom_range(9, 0) == 0)
                    begin
                        fwd = 64'd500;
                        back = 64'd500;
                        proc = '0;
                    end
                    w = $urandom;
                    case ($urandom_range(9, 0))
                        0: shift = rand64();
                        1: shift = '0;
                        default: shift = {{32{w[31]}}, w};
                    endcase
                    br = wall + shift + fwd;
                    bs = br + proc;
                    cr = wall + fwd + proc + back;
                    // Server time longer than the client round trip floors it at zero.
                    if ($urandom_range(11, 0) == 0)
                        bs = br + (cr - wall) + time_t'($urandom_range(100, 1));
                    send_reply(wall, br, bs, cr);
                end
                if ($urandom_range(9, 0) < 3)
                    convert_at(pick_server_time());
            end
            else
            begin
                case ($urandom_range(5, 0))
                    0: send_beat(coe_pkg::CMD_NONE, rand64(), rand64(), rand64(), rand64(),
                                 rand64(), rand64());
                    1: probe_at(rand64());
                    2: send_reply(rand64(), rand64(), rand64(), rand64());
                    3: send_reply(wall, rand64(), rand64(),
                                  wall - 1 - time_t'($urandom_range(1000, 0)));
                    4: send_reply(wall, wall + 100, wall + 50, wall + 200);
                    default: convert_at(rand64());
                endcase
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset configuration.
        send_beat(coe_pkg::CMD_NONE, rand64(), rand64(), rand64(), rand64(), rand64(),
                  rand64());
        convert_at('1);                                  // not synced yet
        send_reply(64'd5, 64'd10, 64'd20, 64'd30);       // nothing pending
        probe_at(64'd0);                                 // first probe, at time zero
        probe_at(64'd5);                                 // blocked by pending reply
        send_reply(64'd1, 64'd2, 64'd3, 64'd4);          // wrong echoed send time
        send_reply(64'd0, 64'd100, 64'd50, 64'd200);     // server send before receive
        send_reply(64'd0, '1, '1, 64'd10);               // positive saturation
        probe_at(64'd1);                                 // last probe at zero: no spacing
        send_reply(64'd1, 64'd0, 64'd0, '1);             // negative saturation, synced
        convert_at(64'd0);                               // clamps at zero
        probe_at(64'd1_000_000_000);                     // one below startup spacing
        probe_at(64'd1_000_000_001);                     // exactly the spacing
        send_reply(64'd1_000_000_001, 64'd1000, 64'd2000, 64'd1_000_000_006);
        convert_at('1);                                  // clamps at the maximum
        probe_at(64'd100);                               // clock went backwards
        probe_at(64'd10_000_000_100);                    // exactly at the timeout
        probe_at(64'd10_000_000_101);                    // just past the timeout
        probe_at(64'd50);                                // before the pending send time
        send_reply(64'd50, 64'd1_000_001, 64'd1_000_004, 64'd60);
        probe_at(64'd40_000_000_000);                    // steady spacing now applies
        send_reply(64'd40_000_000_000, 64'd39_999_999_997, 64'd39_999_999_997,
                   64'd40_000_000_002);                  // two odd negative halves
        convert_at(64'd40_000_000_000);
        probe_at(64'd69_999_999_999);                    // one below steady spacing

        // Random part across several register settings, extremes included.
        run_random(RANDOM_BEATS);
        apply_config('0, '0, '0, 0, 1);
        run_random(RANDOM_BEATS);
        apply_config(time_t'(CFG_MAX), time_t'(CFG_MAX), time_t'(CFG_MAX), 64, 64);
        run_random(RANDOM_BEATS);
        apply_config(time_t'($urandom_range(1_000_000, 1000)), 64'd500, 64'd2000, 3, 8);
        steady_flow <= 1'b1;
        run_random(RANDOM_BEATS);
        steady_flow <= 1'b0;
        apply_config(64'd5000, 64'd100, 64'd100_000, 8, 5);
        run_random(RANDOM_BEATS);

        wait_drained();
        if (fail_count == 0 && owed_count == 0)
            $display("clock_offset_estimator_tb OK");
        else
            $display("clock_offset_estimator_tb NOT OK");
        $finish;
    end

endmodule
